FILE: design/dqsr_pkg.sv
`default_nettype none

package dqsr_pkg;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_CONTAINS   = 3'd4;
    localparam logic [2:0] CMD_REMOVE     = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] data_value;
    } dqsr_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [4:0]         entry_count;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
    } dqsr_out_t;

    typedef struct packed {
        logic       load_item;
        logic       push_front;
        logic       push_back;
        logic       pop_front;
        logic       pop_back;
        logic       search_step;
        logic       shift_step;
        logic       remove_done;
        logic       read_ends;
        logic       load_result;
        logic       status_we;
        logic [1:0] status_val;
        logic       set_found;
    } dqsr_ctl_t;

    typedef struct packed {
        logic [2:0] command;
        logic       empty;
        logic       full;
        logic       pend;
        logic       match;
        logic       at_last;
        logic       shift_more;
        logic       out_free;
    } dqsr_sts_t;

endpackage

`default_nettype wire

FILE: design/deque_with_search_remove_core.sv
// Bounded double-ended queue of signed values that also serves as a bag. Each command item
// (push front, push back, pop front, pop back, contains, remove first match) returns one
// result item with a status, a found flag, the entry count and the front and back values
// after the command. Entries live in a CAPACITY-deep circular memory with one write and two
// registered read ports. The queue takes one command at a time. An accepted command passes
// through the EXEC, ENDS and LOAD states in that order; contains and remove first pass
// through a search state that reads one entry per cycle through a single memory port, from
// the front, until the first match or the last entry, and remove then moves each entry
// behind the match one place toward the front to close the gap. A finished result sits in
// an output register, so the next command can be accepted in the cycle after the result is
// loaded; a command whose result finds that register still full holds until it drains.
`default_nettype none

module deque_with_search_remove_core
    import dqsr_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_ready,
    input  wire dqsr_in_t cmd_item,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output dqsr_out_t     rsp_item
);

    dqsr_ctl_t ctl;
    dqsr_sts_t sts;

    dqsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    dqsr_dp #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_item  (cmd_item),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp_item  (rsp_item),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

`default_nettype wire

FILE: design/dqsr_ctrl.sv
`default_nettype none

module dqsr_ctrl
    import dqsr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire dqsr_sts_t sts,
    output dqsr_ctl_t      ctl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_ENDS   = 3'd4;
    localparam logic [2:0] S_LOAD   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_ENDS;
                case (sts.command)
                    CMD_PUSH_FRONT:
                    begin
                        if (sts.full)
                        begin
                            ctl.status_we  = 1'b1;
                            ctl.status_val = ST_FULL;
                        end
                        else
                        begin
                            ctl.push_front = 1'b1;
                        end
                    end
                    CMD_PUSH_BACK:
                    begin
                        if (sts.full)
                        begin
                            ctl.status_we  = 1'b1;
                            ctl.status_val = ST_FULL;
                        end
                        else
                        begin
                            ctl.push_back = 1'b1;
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (sts.empty)
                        begin
                            ctl.status_we  = 1'b1;
                            ctl.status_val = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.pop_front = 1'b1;
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (sts.empty)
                        begin
                            ctl.status_we  = 1'b1;
                            ctl.status_val = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.pop_back = 1'b1;
                        end
                    end
                    CMD_CONTAINS, CMD_REMOVE:
                    begin
                        state_next = S_SEARCH;
                    end
                    default:
                    begin
                        state_next = S_ENDS;
                    end
                endcase
            end
            S_SEARCH:
            begin
                ctl.search_step = 1'b1;
                if (sts.empty)
                begin
                    state_next = S_ENDS;
                end
                else if (sts.pend && sts.match)
                begin
                    ctl.set_found = 1'b1;
                    if (sts.command == CMD_REMOVE)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_ENDS;
                    end
                end
                else if (sts.pend && sts.at_last)
                begin
                    state_next = S_ENDS;
                end
            end
            S_SHIFT:
            begin
                if (sts.shift_more)
                begin
                    ctl.shift_step = 1'b1;
                end
                else
                begin
                    ctl.remove_done = 1'b1;
                    state_next      = S_ENDS;
                end
            end
            S_ENDS:
            begin
                ctl.read_ends = 1'b1;
                state_next    = S_LOAD;
            end
            S_LOAD:
            begin
                // hold the front read while the output register is busy
                ctl.read_ends = 1'b1;
                if (sts.out_free)
                begin
                    ctl.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/dqsr_dp.sv
`default_nettype none

module dqsr_dp
    import dqsr_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire dqsr_in_t  cmd_item,
    input  wire logic      rsp_ready,
    output logic           rsp_valid,
    output dqsr_out_t      rsp_item,
    input  wire dqsr_ctl_t ctl,
    output dqsr_sts_t      sts
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY + 2);

    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [PW:0]   CAP_S     = (PW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);

    logic [VALUE_WIDTH-1:0] store_mem [CAPACITY];

    logic [AW-1:0]          head_reg;
    logic [CW-1:0]          count_reg;
    logic [PW-1:0]          pos_reg;
    logic                   pend_reg;
    logic [2:0]             command_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [1:0]             status_reg;
    logic                   found_reg;
    logic [VALUE_WIDTH-1:0] rd_a_reg;
    logic [VALUE_WIDTH-1:0] rd_b_reg;
    logic                   out_valid_reg;
    dqsr_out_t              out_reg;

    logic [AW-1:0]          head_next;
    logic [CW-1:0]          count_next;
    logic [AW-1:0]          head_dec;
    logic [AW-1:0]          head_inc;
    logic [AW-1:0]          addr_a;
    logic [AW-1:0]          addr_b;
    logic [PW-1:0]          back_pos;
    logic [PW-1:0]          count_pos;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [VALUE_WIDTH+31:0] in_ext;
    logic [VALUE_WIDTH+31:0] front_ext;
    logic [VALUE_WIDTH+31:0] back_ext;
    logic [CW+4:0]          count_ext;
    dqsr_out_t              result;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                              input logic [PW-1:0] p);
        logic [PW:0] s;
        s = (PW + 1)'(h) + (PW + 1)'(p);
        if (s >= CAP_S)
        begin
            s = s - CAP_S;
        end
        if (s >= CAP_S)
        begin
            s = s - CAP_S;
        end
        return s[AW-1:0];
    endfunction

    assign head_dec  = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);
    assign head_inc  = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
    assign count_pos = PW'(count_reg);
    assign back_pos  = (count_reg == '0) ? '0 : count_pos - PW'(1);
    assign addr_a    = ctl.read_ends ? head_reg : slot_of(head_reg, pos_reg);
    assign addr_b    = slot_of(head_reg, back_pos);
    assign in_ext    = {{VALUE_WIDTH{1'b0}}, cmd_item.data_value};

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = slot_of(head_reg, pos_reg - PW'(2));
        wr_data = rd_a_reg;
        if (ctl.push_front)
        begin
            wr_en   = 1'b1;
            wr_addr = head_dec;
            wr_data = val_reg;
        end
        else if (ctl.push_back)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head_reg, count_pos);
            wr_data = val_reg;
        end
        else if (ctl.shift_step)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= store_mem[addr_a];
        rd_b_reg <= store_mem[addr_b];
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.push_front)
        begin
            head_next  = head_dec;
            count_next = count_reg + CW'(1);
        end
        else if (ctl.push_back)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.pop_front)
        begin
            head_next  = head_inc;
            count_next = count_reg - CW'(1);
        end
        else if (ctl.pop_back || ctl.remove_done)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (ctl.load_item)
            begin
                pos_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (ctl.search_step || ctl.shift_step)
            begin
                pos_reg  <= pos_reg + PW'(1);
                pend_reg <= 1'b1;
            end
            if (ctl.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            command_reg <= cmd_item.command;
            val_reg     <= in_ext[VALUE_WIDTH-1:0];
            status_reg  <= ST_OK;
            found_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.status_we)
            begin
                status_reg <= ctl.status_val;
            end
            if (ctl.set_found)
            begin
                found_reg <= 1'b1;
            end
        end
        if (ctl.load_result)
        begin
            out_reg <= result;
        end
    end

    assign front_ext = {32'b0, rd_a_reg};
    assign back_ext  = {32'b0, rd_b_reg};
    assign count_ext = {5'b0, count_reg};

    always_comb
    begin
        result.status      = status_reg;
        result.found       = found_reg;
        result.entry_count = count_ext[4:0];
        if (count_reg == '0)
        begin
            result.front_value = '0;
            result.back_value  = '0;
        end
        else
        begin
            result.front_value = front_ext[31:0];
            result.back_value  = back_ext[31:0];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

    assign sts.command    = command_reg;
    assign sts.empty      = (count_reg == '0);
    assign sts.full       = (count_reg == CAP_C);
    assign sts.pend       = pend_reg;
    assign sts.match      = (rd_a_reg == val_reg);
    assign sts.at_last    = (pos_reg == count_pos);
    assign sts.shift_more = (pos_reg <= count_pos);
    assign sts.out_free   = !out_valid_reg || rsp_ready;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.push_front || ctl.push_back) |-> (count_reg != CAP_C))
        else $error("push into a full queue");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.pop_front || ctl.pop_back || ctl.remove_done) |-> (count_reg != '0))
        else $error("entry dropped from an empty queue");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_result |-> (!out_valid_reg || rsp_ready))
        else $error("pending result overwritten");

    a_shift_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift_step |-> (command_reg == CMD_REMOVE) && found_reg)
        else $error("entries moved without a match");
`endif

endmodule

`default_nettype wire
